FILE: rtl/core/trsd_pkg.sv
// Shared types and constants for the transparent RLE sprite decoder.
// No dependencies; used by every module in rtl/core.
`default_nettype none
package trsd_pkg;
	localparam int OFFSET_BITS = 20;
	localparam int WOFF_W      = 20;
	localparam int LSKIP_W     = 16;

	typedef logic [OFFSET_BITS-1:0] cursor_t;
	typedef logic [WOFF_W-1:0]      woff_t;

	localparam logic [1:0] PH_SKIP  = 2'd0;
	localparam logic [1:0] PH_COUNT = 2'd1;
	localparam logic [1:0] PH_COPY  = 2'd2;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		woff_t      write_offset;
		logic [7:0] pixel_value;
	} result_t;
endpackage
`default_nettype wire

FILE: rtl/core/transparent_rle_sprite_decoder_unit.sv
// Transparent RLE sprite decoder, top level.
// Depends on trsd_pkg, trsd_in_stage, trsd_decode, trsd_out_reg.
//
// Input channel (in_valid/in_ready): one program byte per item, code_byte
// plus last_byte marking the final byte of the program. Output channel
// (out_valid/out_ready): one pixel write (write_offset, pixel_value) per
// pixel byte; skip and count bytes give no output item.
// The end-of-line stride is written through cfg_we/cfg_data; the user must do so
// only while the block is idle, which the block itself does not enforce.
// Throughput: one item per cycle while in_ready is high. A pixel byte is held in
// the input register, then decoded into the result register that drives the output.
// When the receiver stalls, the result register holds its pixel and the
// input register holds the next byte; in_ready drops only when both are
// occupied. Items that make no pixel pass the decode stage even while a
// pixel waits.
// Reset: stride, phase, held skip, copy count and cursor clear to zero;
// both registers empty. A last_byte item also returns the decode state to
// zero after it is processed.
`default_nettype none
module transparent_rle_sprite_decoder_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [trsd_pkg::LSKIP_W-1:0]   cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [7:0]                     code_byte,
	input  wire logic                           last_byte,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [trsd_pkg::WOFF_W-1:0]         write_offset,
	output logic [7:0]                          pixel_value
);
	logic [trsd_pkg::LSKIP_W-1:0] eol_stride_q;
	logic                         s1_valid;
	trsd_pkg::item_t              s1_item;
	logic                         advance;
	logic                         res_valid;
	trsd_pkg::result_t            res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eol_stride_q <= '0;
		end else if (cfg_we) begin
			eol_stride_q <= cfg_data;
		end
	end

	// a pixel item needs a free result slot; others always move on
	assign advance = s1_valid && (!res_valid || !out_valid || out_ready);

	trsd_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.code_byte (code_byte),
		.last_byte (last_byte),
		.advance   (advance),
		.s1_valid  (s1_valid),
		.s1_item   (s1_item)
	);

	trsd_decode u_dec (
		.clk        (clk),
		.arst_n     (arst_n),
		.eol_stride (eol_stride_q),
		.advance    (advance),
		.s1_item    (s1_item),
		.res_valid  (res_valid),
		.res        (res)
	);

	trsd_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && res_valid),
		.res_valid    (res_valid),
		.res          (res),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.write_offset (write_offset),
		.pixel_value  (pixel_value)
	);
endmodule
`default_nettype wire

FILE: rtl/core/trsd_in_stage.sv
// Input register stage for the sprite decoder.
// Depends on trsd_pkg.
`default_nettype none
module trsd_in_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    code_byte,
	input  wire logic          last_byte,
	input  wire logic          advance,
	output logic               s1_valid,
	output trsd_pkg::item_t    s1_item
);
	logic            valid_s1;
	trsd_pkg::item_t item_s1;

	assign in_ready = !valid_s1 || advance;
	assign s1_valid = valid_s1;
	assign s1_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.code_byte <= code_byte;
			item_s1.last_byte <= last_byte;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/trsd_decode.sv
// Run-length decode state (phase, held skip, copy count, cursor) and its
// next-state update, registered on advance. Depends on trsd_pkg.
`default_nettype none
module trsd_decode (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [trsd_pkg::LSKIP_W-1:0]  eol_stride,
	input  wire logic                          advance,
	input  wire trsd_pkg::item_t               s1_item,
	output logic                               res_valid,
	output trsd_pkg::result_t                  res
);
	logic [1:0]        phase_q, phase_d;
	logic [7:0]        held_skip_q, held_skip_d;
	logic [7:0]        copy_rem_q, copy_rem_d;
	trsd_pkg::cursor_t cursor_q, cursor_d;
	logic [7:0]        rem_dec;

	assign rem_dec   = copy_rem_q - 8'd1;
	assign res_valid = (phase_q == trsd_pkg::PH_COPY);
	assign res.write_offset = trsd_pkg::woff_t'(cursor_q);
	assign res.pixel_value  = s1_item.code_byte;

	always_comb begin
		phase_d     = phase_q;
		held_skip_d = held_skip_q;
		copy_rem_d  = copy_rem_q;
		cursor_d    = cursor_q;
		case (phase_q)
			trsd_pkg::PH_COUNT: begin
				if (s1_item.code_byte == 8'd0 && held_skip_q == 8'd0) begin
					// end of line
					cursor_d = cursor_q + trsd_pkg::cursor_t'(eol_stride);
					phase_d  = trsd_pkg::PH_SKIP;
				end else begin
					cursor_d = cursor_q + trsd_pkg::cursor_t'(held_skip_q);
					if (s1_item.code_byte == 8'd0) begin
						phase_d = trsd_pkg::PH_SKIP;
					end else begin
						copy_rem_d = s1_item.code_byte;
						phase_d    = trsd_pkg::PH_COPY;
					end
				end
			end
			trsd_pkg::PH_COPY: begin
				cursor_d   = cursor_q + trsd_pkg::cursor_t'(1);
				copy_rem_d = rem_dec;
				if (rem_dec == 8'd0) begin
					phase_d = trsd_pkg::PH_SKIP;
				end
			end
			default: begin
				held_skip_d = s1_item.code_byte;
				phase_d     = trsd_pkg::PH_COUNT;
			end
		endcase
		if (s1_item.last_byte) begin
			phase_d     = trsd_pkg::PH_SKIP;
			held_skip_d = 8'd0;
			copy_rem_d  = 8'd0;
			cursor_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= trsd_pkg::PH_SKIP;
			held_skip_q <= 8'd0;
			copy_rem_q  <= 8'd0;
			cursor_q    <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			held_skip_q <= held_skip_d;
			copy_rem_q  <= copy_rem_d;
			cursor_q    <= cursor_d;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/trsd_out_reg.sv
// Result register holding one pixel write until the receiver takes it.
// Depends on trsd_pkg.
`default_nettype none
module trsd_out_reg (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      load,
	input  wire logic                      res_valid,
	input  wire trsd_pkg::result_t         res,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [trsd_pkg::WOFF_W-1:0]    write_offset,
	output logic [7:0]                     pixel_value
);
	logic              valid_q;
	trsd_pkg::result_t res_q;

	assign out_valid    = valid_q;
	assign write_offset = res_q.write_offset;
	assign pixel_value  = res_q.pixel_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res_valid;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res_valid) begin
			res_q <= res;
		end
	end
endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for transparent_rle_sprite_decoder_unit.
// Depends on trsd_pkg and the decoder RTL; the expected pixel writes come from a
// cycle-free model of the skip/count/copy decoder kept inside this module.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 4;

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          cfg_we      = 1'b0;
	logic [trsd_pkg::LSKIP_W-1:0]  cfg_data    = '0;
	logic                          in_valid    = 1'b0;
	logic                          in_ready;
	logic [7:0]                    code_byte   = '0;
	logic                          last_byte   = 1'b0;
	logic                          out_valid;
	logic                          out_ready   = 1'b0;
	logic [trsd_pkg::WOFF_W-1:0]   write_offset;
	logic [7:0]                    pixel_value;

	// decoder model state
	logic [1:0]                    dec_phase;
	logic [7:0]                    dec_skip;
	logic [7:0]                    dec_left;
	trsd_pkg::cursor_t             dec_cursor;
	logic [trsd_pkg::LSKIP_W-1:0]  eol_stride_q;

	trsd_pkg::result_t   pixel_q[$];
	int                  err_cnt     = 0;
	int                  bytes_sent  = 0;
	int                  idle_cycles = 0;
	int                  send_idle_pct = 0;
	int                  stall_pct     = 0;

	transparent_rle_sprite_decoder_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.code_byte    (code_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.write_offset (write_offset),
		.pixel_value  (pixel_value)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void clear_decoder();
		dec_phase  = trsd_pkg::PH_SKIP;
		dec_skip   = '0;
		dec_left   = '0;
		dec_cursor = '0;
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic last);
		trsd_pkg::result_t px;
		case (dec_phase)
			trsd_pkg::PH_COUNT: begin
				if (b == 8'd0 && dec_skip == 8'd0) begin
					// end of line
					dec_cursor = trsd_pkg::cursor_t'(dec_cursor + eol_stride_q);
					dec_phase  = trsd_pkg::PH_SKIP;
				end else begin
					dec_cursor = trsd_pkg::cursor_t'(dec_cursor + dec_skip);
					if (b == 8'd0) begin
						dec_phase = trsd_pkg::PH_SKIP;
					end else begin
						dec_left  = b;
						dec_phase = trsd_pkg::PH_COPY;
					end
				end
			end
			trsd_pkg::PH_COPY: begin
				px.write_offset = dec_cursor[trsd_pkg::WOFF_W-1:0];
				px.pixel_value  = b;
				pixel_q.push_back(px);
				dec_cursor = trsd_pkg::cursor_t'(dec_cursor + 1);
				dec_left   = dec_left - 8'd1;
				if (dec_left == 8'd0)
					dec_phase = trsd_pkg::PH_SKIP;
			end
			default: begin
				dec_skip  = b;
				dec_phase = trsd_pkg::PH_COUNT;
			end
		endcase
		if (last)
			clear_decoder();
	endfunction

	// results are checked before this edge's accepted item is modeled
	always @(posedge clk) begin
		trsd_pkg::result_t exp_px;
		if (!arst_n) begin
			clear_decoder();
			eol_stride_q = '0;
		end else begin
			if (out_valid && out_ready) begin
				if (pixel_q.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected item: expected none, actual offset %h pixel %h",
						$time, write_offset, pixel_value);
				end else begin
					exp_px = pixel_q.pop_front();
					if (write_offset !== exp_px.write_offset) begin
						err_cnt++;
						$display("%0t: write_offset mismatch: expected %h, actual %h",
							$time, exp_px.write_offset, write_offset);
					end
					if (pixel_value !== exp_px.pixel_value) begin
						err_cnt++;
						$display("%0t: pixel_value mismatch: expected %h, actual %h",
							$time, exp_px.pixel_value, pixel_value);
					end
				end
			end
			if (cfg_we)
				eol_stride_q = cfg_data;
			if (in_valid && in_ready)
				decode_byte(code_byte, last_byte);
		end
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, idle_cycles);
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid  <= 1'b1;
		code_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	// skip/count bytes give no item, so let the pipe settle past the last pixel
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_eol_stride(input logic [trsd_pkg::LSKIP_W-1:0] value);
		wait_drained();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	function automatic logic [7:0] pick_skip();
		return ($urandom_range(1) == 0) ? 8'($urandom_range(4)) : 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return 8'($urandom_range(1, 6));
		else if (r < 85)
			return 8'd0;
		else if (r < 95)
			return 8'($urandom_range(7, 40));
		return 8'($urandom_range(41, 255));
	endfunction

	// well-formed program of n_lines lines; truncated ones end at a random byte
	task automatic send_program(input int n_lines, input bit truncate);
		logic [7:0] prog[$];
		logic [7:0] cnt;
		int         cut;
		for (int l = 0; l < n_lines; l++) begin
			repeat ($urandom_range(0, 3)) begin
				cnt = pick_count();
				prog.push_back(pick_skip());
				prog.push_back(cnt);
				repeat (cnt) prog.push_back(8'($urandom_range(255)));
			end
			prog.push_back(8'd0);
			prog.push_back(8'd0);
		end
		cut = truncate ? int'($urandom_range(0, prog.size() - 1)) : prog.size() - 1;
		for (int i = 0; i <= cut; i++)
			send_byte(prog[i], i == cut);
	endtask

	task automatic test_directed();
		logic [7:0] b[20] = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd3, 8'd2, 8'h00, 8'hFF,
			8'd0, 8'd0, 8'd7, 8'd1, 8'd3, 8'h55, 8'hAA, 8'd0, 8'd1, 8'h81, 8'd2, 8'd0};
		// truncated after a skip, mid-copy, on a final pixel, on a count byte
		logic       l[20] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
			1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
		send_idle_pct = 0;
		stall_pct     = 0;
		write_eol_stride(16'd5);
		for (int i = 0; i < 20; i++)
			send_byte(b[i], l[i]);
		wait_drained();
	endtask

	task automatic test_eol_stride_extremes();
		logic [trsd_pkg::LSKIP_W-1:0] vals[2] = '{16'h0000, 16'hFFFF};
		send_idle_pct = 10;
		stall_pct     = 10;
		foreach (vals[k]) begin
			write_eol_stride(vals[k]);
			// enough lines to wrap the cursor at full stride
			repeat (18) begin
				send_byte(8'd0, 1'b0);
				send_byte(8'd0, 1'b0);
			end
			send_byte(8'd1, 1'b0);
			send_byte(8'd2, 1'b0);
			send_byte(8'($urandom_range(255)), 1'b0);
			send_byte(8'($urandom_range(255)), 1'b1);
		end
		wait_drained();
	endtask

	task automatic test_random_programs(input int idle_pct, input int stall, input int n_bytes);
		int start;
		int r;
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		write_eol_stride(($urandom_range(3) == 0) ? 16'($urandom_range(65535))
			: 16'($urandom_range(64)));
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			r = $urandom_range(9);
			if (r == 0) begin
				repeat ($urandom_range(1, 12))
					send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
			end else begin
				send_program($urandom_range(1, 4), r == 1);
			end
		end
		wait_drained();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_eol_stride_extremes();
		test_random_programs(0, 0, 460);
		test_random_programs(62, 0, 460);
		test_random_programs(0, 62, 460);
		test_random_programs(10, 10, 460);
		repeat (8) @(posedge clk);
		if (err_cnt == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

FILE: sim.f
rtl/core/trsd_pkg.sv
rtl/core/trsd_in_stage.sv
rtl/core/trsd_decode.sv
rtl/core/trsd_out_reg.sv
rtl/core/transparent_rle_sprite_decoder_unit.sv
tb/sv/testbench.sv
